// ----- hdl/rk4_pkg.sv -----
// Shared types, constants and codes of the RK4 stage increment core.
package rk4_pkg;

	localparam int VALUE_WIDTH  = 32;
	localparam int COMPARTMENTS = 256;
	localparam int IDX_WIDTH    = $clog2(COMPARTMENTS);
	localparam int TS_WIDTH     = 31;
	localparam int MODE_WIDTH   = 5;
	localparam int ROW_WIDTH    = 3 * VALUE_WIDTH;
	localparam int DVD_WIDTH    = 48;
	localparam int CNT_WIDTH    = $clog2(DVD_WIDTH);

	localparam int CDIV_CHUNK  = 18;
	localparam int CDV_WIDTH   = 2 * CDIV_CHUNK;
	localparam int THIRD_SHIFT = 21;
	localparam logic [CDIV_CHUNK+1:0] THIRD_RECIP = 20'd699051;

	localparam logic signed [MODE_WIDTH-1:0] MODE_UNDO_RK    = -5'sd2;
	localparam logic signed [MODE_WIDTH-1:0] MODE_UNDO_EULER = -5'sd1;
	localparam logic signed [MODE_WIDTH-1:0] MODE_EULER      = 5'sd0;
	localparam logic signed [MODE_WIDTH-1:0] MODE_RK1        = 5'sd1;
	localparam logic signed [MODE_WIDTH-1:0] MODE_RK2        = 5'sd2;
	localparam logic signed [MODE_WIDTH-1:0] MODE_RK3        = 5'sd3;
	localparam logic signed [MODE_WIDTH-1:0] MODE_RK4        = 5'sd4;
	localparam logic signed [MODE_WIDTH-1:0] MODE_ERR_CHECK  = 5'sd10;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_DV,
		ST_EXEC,
		ST_DIV6,
		ST_DIV3,
		ST_DIVT,
		ST_FIN
	} rk4_state_t;

	typedef enum logic [1:0] {
		DIV_SIX,
		DIV_THREE,
		DIV_TS
	} rk4_div_sel_t;

	typedef struct packed {
		logic         capture;
		logic         mul;
		logic         dv;
		logic         exec;
		logic         div_go;
		logic         div_take;
		rk4_div_sel_t go_sel;
		rk4_div_sel_t take_sel;
		logic         fin;
	} rk4_cmd_t;

	typedef struct packed {
		logic stage4;
		logic ts_zero;
		logic div_done;
	} rk4_sts_t;

endpackage

// ----- hdl/rk4_stage_increment_core.sv -----
// Top level of the RK4 stage increment core: controller plus datapath.
//
// channel  direction  handshake                 payload
// input    in         start high, busy low      compartment, stage_mode, rate,
//                                               time_step, clear_max_error
// result   out        done, one cycle           increment, max_error, divide_by_zero
//
// Most modes: the word steps through MUL, DV, EXEC and FIN, and done is registered from FIN.
// Stage 4: division by 6 then by 3, each a registered reciprocal multiply, then a
// 48-step restoring division by the time step, skipped with a zero time step.
// Reset clears control state and the per-compartment valid bits at once.
// The receiver cannot stall; busy holds off a new word until the result is out.
module rk4_stage_increment_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [rk4_pkg::IDX_WIDTH-1:0]         compartment,
	input  logic signed [rk4_pkg::MODE_WIDTH-1:0] stage_mode,
	input  logic signed [31:0]                    rate,
	input  logic [rk4_pkg::TS_WIDTH-1:0]          time_step,
	input  logic                                  clear_max_error,
	output logic                                  done,
	output logic signed [31:0]                    increment,
	output logic [30:0]                           max_error,
	output logic                                  divide_by_zero
);

	rk4_pkg::rk4_cmd_t cmd;
	rk4_pkg::rk4_sts_t sts;

	rk4_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	rk4_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.compartment     (compartment),
		.stage_mode      (stage_mode),
		.rate            (rate),
		.time_step       (time_step),
		.clear_max_error (clear_max_error),
		.done            (done),
		.increment       (increment),
		.max_error       (max_error),
		.divide_by_zero  (divide_by_zero)
	);

endmodule

// ----- hdl/rk4_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rk4_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/rk4_div.sv -----
// Restoring divider, one quotient bit per cycle.
module rk4_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           go,
	input  logic [rk4_pkg::DVD_WIDTH-1:0]  dividend,
	input  logic [rk4_pkg::TS_WIDTH-1:0]   divisor,
	output logic                           done,
	output logic [rk4_pkg::DVD_WIDTH-1:0]  quotient
);

	logic                          run_q;
	logic                          done_q;
	logic [rk4_pkg::CNT_WIDTH-1:0] cnt_q;
	logic [rk4_pkg::TS_WIDTH-1:0]  rem_q;
	logic [rk4_pkg::TS_WIDTH-1:0]  div_q;
	logic [rk4_pkg::DVD_WIDTH-1:0] quo_q;
	logic [rk4_pkg::TS_WIDTH:0]    cand;
	logic [rk4_pkg::TS_WIDTH:0]    diff;
	logic                          fits;

	assign cand = {rem_q, quo_q[rk4_pkg::DVD_WIDTH-1]};
	assign diff = cand - {1'b0, div_q};
	assign fits = cand >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == rk4_pkg::CNT_WIDTH'(rk4_pkg::DVD_WIDTH - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= fits ? diff[rk4_pkg::TS_WIDTH-1:0] : cand[rk4_pkg::TS_WIDTH-1:0];
			quo_q <= {quo_q[rk4_pkg::DVD_WIDTH-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- hdl/rk4_datapath.sv -----
// Datapath: increment store, product, stage arithmetic, divider and result registers.
module rk4_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  rk4_pkg::rk4_cmd_t                     cmd,
	output rk4_pkg::rk4_sts_t                     sts,
	input  logic [rk4_pkg::IDX_WIDTH-1:0]         compartment,
	input  logic signed [rk4_pkg::MODE_WIDTH-1:0] stage_mode,
	input  logic signed [31:0]                    rate,
	input  logic [rk4_pkg::TS_WIDTH-1:0]          time_step,
	input  logic                                  clear_max_error,
	output logic                                  done,
	output logic signed [31:0]                    increment,
	output logic [30:0]                           max_error,
	output logic                                  divide_by_zero
);

	localparam int VW = rk4_pkg::VALUE_WIDTH;
	localparam int XW = VW + 8;
	localparam int CW = rk4_pkg::CDIV_CHUNK + 2;

	function automatic logic signed [VW-1:0] sat(input logic signed [XW-1:0] x);
		logic signed [XW-1:0] hi;
		logic signed [XW-1:0] lo;
		hi = XW'({1'b0, {(VW-1){1'b1}}});
		lo = -hi - 1;
		if (x > hi) begin
			return {1'b0, {(VW-1){1'b1}}};
		end else if (x < lo) begin
			return {1'b1, {(VW-1){1'b0}}};
		end
		return x[VW-1:0];
	endfunction

	function automatic logic signed [VW-1:0] sat_mag(input logic [rk4_pkg::DVD_WIDTH-1:0] m,
		input logic neg);
		logic [rk4_pkg::DVD_WIDTH-1:0] lim;
		lim = rk4_pkg::DVD_WIDTH'({1'b0, {(VW-1){1'b1}}});
		if (neg) begin
			if (m > lim + 1'b1) begin
				return {1'b1, {(VW-1){1'b0}}};
			end
			return -(m[VW-1:0]);
		end
		if (m > lim) begin
			return {1'b0, {(VW-1){1'b1}}};
		end
		return m[VW-1:0];
	endfunction

	function automatic logic signed [VW-1:0] half(input logic signed [VW-1:0] x);
		logic signed [VW:0] s;
		s = {x[VW-1], x} + {{VW{1'b0}}, x[VW-1]};
		return s[VW:1];
	endfunction

	function automatic logic [XW-1:0] absx(input logic signed [XW-1:0] x);
		return x[XW-1] ? $unsigned(-x) : $unsigned(x);
	endfunction

	function automatic logic [CW-1:0] third(input logic [CW-1:0] x);
		logic [2*CW-1:0] p;
		p = x * rk4_pkg::THIRD_RECIP;
		return CW'(p >> rk4_pkg::THIRD_SHIFT);
	endfunction

	logic [rk4_pkg::COMPARTMENTS-1:0]         valid_q;
	logic                                     vld_q;
	logic [rk4_pkg::ROW_WIDTH-1:0]            rdata;
	logic [rk4_pkg::IDX_WIDTH-1:0]            idx_q;
	logic signed [rk4_pkg::MODE_WIDTH-1:0]    mode_q;
	logic signed [VW-1:0]                     rate_q;
	logic [rk4_pkg::TS_WIDTH-1:0]             ts_q;
	logic signed [VW-1:0]                     t1_q, t2_q, t3_q;
	logic signed [VW-1:0]                     n1_q, n2_q, n3_q;
	logic signed [VW-1:0]                     inc_q;
	logic signed [VW-1:0]                     dv_q;
	logic [VW+rk4_pkg::TS_WIDTH-1:0]          prod_q;
	logic                                     neg_q;
	logic                                     wr_q;
	logic [VW:0]                              err_q;
	logic                                     done_q;
	logic signed [VW-1:0]                     increment_q;
	logic [30:0]                              max_error_q;
	logic                                     dz_q;
	logic                                     c_v_s1, c_v_s2, c_v_s3;
	logic [rk4_pkg::CDIV_CHUNK-1:0]           c_hi_s1, c_lo_s1;
	logic [rk4_pkg::CDIV_CHUNK-1:0]           c_qh_s2;
	logic [CW-1:0]                            c_rest_s2;
	logic [rk4_pkg::CDV_WIDTH-1:0]            c_quo_s3;

	logic signed [VW-1:0]                     r1, r2, r3, x_op;
	logic [VW-1:0]                            x_mag;
	logic [VW+rk4_pkg::TS_WIDTH-17:0]         p_mag;
	logic signed [VW-1:0]                     dv_c;
	logic signed [XW-1:0]                     e1, e2, e3, edv, tmp6, tmp3, ediff;
	logic [XW-1:0]                            emag;
	logic [rk4_pkg::DVD_WIDTH-1:0]            dvd;
	logic                                     t_go;
	logic                                     div_done;
	logic [rk4_pkg::DVD_WIDTH-1:0]            quo;
	logic                                     c_go;
	logic [rk4_pkg::CDV_WIDTH-1:0]            c_dvd;
	logic [CW-1:0]                            c_qh, c_rh, c_ql;
	logic signed [VW-1:0]                     x1, x2, x3, xinc;
	logic                                     xwr;
	logic signed [VW-1:0]                     w1, inc_fin;
	logic                                     stage4;

	assign r1   = vld_q ? rdata[3*VW-1:2*VW] : '0;
	assign r2   = vld_q ? rdata[2*VW-1:VW] : '0;
	assign r3   = vld_q ? rdata[VW-1:0] : '0;
	assign x_op = mode_q[rk4_pkg::MODE_WIDTH-1] ? r1 : rate_q;
	assign x_mag = x_op[VW-1] ? $unsigned(-x_op) : $unsigned(x_op);
	assign p_mag = prod_q[VW+rk4_pkg::TS_WIDTH-1:16];
	assign dv_c  = sat_mag(rk4_pkg::DVD_WIDTH'(p_mag), neg_q);

	assign e1    = XW'(t1_q);
	assign e2    = XW'(t2_q);
	assign e3    = XW'(t3_q);
	assign edv   = XW'(dv_q);
	assign tmp6  = e1 + e2 + e2 + e3 + e3 + edv;
	assign tmp3  = -e1 + e3 + e3 + edv + edv;
	assign ediff = edv - e3;
	assign emag  = absx(ediff);
	assign stage4 = mode_q == rk4_pkg::MODE_RK4;

	assign t_go = cmd.div_go && cmd.go_sel == rk4_pkg::DIV_TS;
	assign dvd  = {(t1_q[VW-1] ? $unsigned(-t1_q) : $unsigned(t1_q)), 16'b0};

	rk4_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (t_go),
		.dividend (dvd),
		.divisor  (ts_q),
		.done     (div_done),
		.quotient (quo)
	);

	assign c_go  = cmd.div_go && cmd.go_sel != rk4_pkg::DIV_TS;
	assign c_dvd = (cmd.go_sel == rk4_pkg::DIV_THREE) ?
		rk4_pkg::CDV_WIDTH'(absx(tmp3)) : rk4_pkg::CDV_WIDTH'(absx(tmp6) >> 1);
	assign c_qh  = third({2'b0, c_hi_s1});
	assign c_rh  = {2'b0, c_hi_s1} - (c_qh << 1) - c_qh;
	assign c_ql  = third(c_rest_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_v_s1 <= 1'b0;
			c_v_s2 <= 1'b0;
			c_v_s3 <= 1'b0;
		end else begin
			c_v_s1 <= c_go;
			c_v_s2 <= c_v_s1;
			c_v_s3 <= c_v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (c_go) begin
			c_hi_s1 <= c_dvd[rk4_pkg::CDV_WIDTH-1:rk4_pkg::CDIV_CHUNK];
			c_lo_s1 <= c_dvd[rk4_pkg::CDIV_CHUNK-1:0];
		end
		c_qh_s2   <= c_qh[rk4_pkg::CDIV_CHUNK-1:0];
		c_rest_s2 <= {c_rh[1:0], c_lo_s1};
		c_quo_s3  <= {c_qh_s2, rk4_pkg::CDIV_CHUNK'(0)} + rk4_pkg::CDV_WIDTH'(c_ql);
	end

	always_comb begin
		x1   = t1_q;
		x2   = t2_q;
		x3   = t3_q;
		xinc = '0;
		xwr  = 1'b1;
		unique case (mode_q)
			rk4_pkg::MODE_EULER: begin
				x1   = rate_q;
				x2   = dv_q;
				x3   = dv_q;
				xinc = dv_q;
			end
			rk4_pkg::MODE_RK1: begin
				x1   = dv_q;
				xinc = half(dv_q);
			end
			rk4_pkg::MODE_RK2: begin
				x2   = dv_q;
				xinc = half(sat(edv - e1));
			end
			rk4_pkg::MODE_RK3: begin
				x3   = dv_q;
				xinc = sat(edv - XW'(half(t2_q)));
			end
			rk4_pkg::MODE_RK4: begin
				xwr = 1'b1;
			end
			rk4_pkg::MODE_UNDO_EULER: begin
				x2   = dv_q;
				x3   = dv_q;
				xinc = sat(edv - e2);
			end
			rk4_pkg::MODE_UNDO_RK: begin
				x1   = dv_q;
				xinc = sat(XW'(half(dv_q)) - e2);
			end
			default: begin
				xwr = 1'b0;
			end
		endcase
	end

	always_comb begin
		w1 = n1_q;
		inc_fin = inc_q;
		if (stage4) begin
			inc_fin = sat(XW'(n2_q) - e3);
			if (ts_q == '0) begin
				if (t1_q > 0) begin
					w1 = {1'b0, {(VW-1){1'b1}}};
				end else if (t1_q < 0) begin
					w1 = {1'b1, {(VW-1){1'b0}}};
				end else begin
					w1 = '0;
				end
			end
		end
	end

	rk4_ram #(
		.WIDTH (rk4_pkg::ROW_WIDTH),
		.DEPTH (rk4_pkg::COMPARTMENTS)
	) u_ram (
		.clk   (clk),
		.we    (cmd.fin && wr_q),
		.waddr (idx_q),
		.wdata ({w1, n2_q, n3_q}),
		.re    (cmd.capture),
		.raddr (compartment),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			err_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.fin;
			if (cmd.fin && wr_q) begin
				valid_q[idx_q] <= 1'b1;
			end
			if (cmd.capture && clear_max_error) begin
				err_q <= '0;
			end else if (cmd.exec && mode_q == rk4_pkg::MODE_ERR_CHECK
				&& emag[VW:0] > err_q) begin
				err_q <= emag[VW:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_q  <= compartment;
			mode_q <= stage_mode;
			rate_q <= rate;
			ts_q   <= time_step;
			vld_q  <= valid_q[compartment];
		end
		if (cmd.mul) begin
			t1_q   <= r1;
			t2_q   <= r2;
			t3_q   <= r3;
			neg_q  <= x_op[VW-1];
			prod_q <= x_mag * ts_q;
		end
		if (cmd.dv) begin
			dv_q <= dv_c;
		end
		if (cmd.exec) begin
			n1_q  <= x1;
			n2_q  <= x2;
			n3_q  <= x3;
			inc_q <= xinc;
			wr_q  <= xwr;
		end
		if (cmd.div_take) begin
			case (cmd.take_sel)
				rk4_pkg::DIV_SIX:
					n2_q <= sat_mag(rk4_pkg::DVD_WIDTH'(c_quo_s3), tmp6[XW-1]);
				rk4_pkg::DIV_THREE:
					n3_q <= sat_mag(rk4_pkg::DVD_WIDTH'(c_quo_s3), tmp3[XW-1]);
				default:
					n1_q <= sat_mag(quo, t1_q[VW-1]);
			endcase
		end
		if (cmd.fin) begin
			increment_q <= inc_fin;
			max_error_q <= (err_q > (VW+1)'(31'h7FFF_FFFF)) ? 31'h7FFF_FFFF : err_q[30:0];
			dz_q        <= stage4 && ts_q == '0;
		end
	end

	assign sts.stage4   = stage4;
	assign sts.ts_zero  = ts_q == '0;
	assign sts.div_done = div_done | c_v_s3;

	assign done           = done_q;
	assign increment      = increment_q;
	assign max_error      = max_error_q;
	assign divide_by_zero = dz_q;

endmodule

// ----- hdl/rk4_ctrl.sv -----
// Controller state machine sequencing one word through the datapath.
module rk4_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  rk4_pkg::rk4_sts_t sts,
	output rk4_pkg::rk4_cmd_t cmd
);

	rk4_pkg::rk4_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rk4_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rk4_pkg::ST_IDLE: if (start) state_d = rk4_pkg::ST_MUL;
			rk4_pkg::ST_MUL:  state_d = rk4_pkg::ST_DV;
			rk4_pkg::ST_DV:   state_d = rk4_pkg::ST_EXEC;
			rk4_pkg::ST_EXEC: state_d = sts.stage4 ? rk4_pkg::ST_DIV6 : rk4_pkg::ST_FIN;
			rk4_pkg::ST_DIV6: if (sts.div_done) state_d = rk4_pkg::ST_DIV3;
			rk4_pkg::ST_DIV3: begin
				if (sts.div_done) begin
					state_d = sts.ts_zero ? rk4_pkg::ST_FIN : rk4_pkg::ST_DIVT;
				end
			end
			rk4_pkg::ST_DIVT: if (sts.div_done) state_d = rk4_pkg::ST_FIN;
			rk4_pkg::ST_FIN:  state_d = rk4_pkg::ST_IDLE;
			default:          state_d = rk4_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.go_sel   = rk4_pkg::DIV_SIX;
		cmd.take_sel = rk4_pkg::DIV_SIX;
		unique case (state_q)
			rk4_pkg::ST_IDLE: cmd.capture = start;
			rk4_pkg::ST_MUL:  cmd.mul = 1'b1;
			rk4_pkg::ST_DV:   cmd.dv = 1'b1;
			rk4_pkg::ST_EXEC: begin
				cmd.exec   = 1'b1;
				cmd.div_go = sts.stage4;
			end
			rk4_pkg::ST_DIV6: begin
				cmd.div_take = sts.div_done;
				cmd.div_go   = sts.div_done;
				cmd.go_sel   = rk4_pkg::DIV_THREE;
			end
			rk4_pkg::ST_DIV3: begin
				cmd.div_take = sts.div_done;
				cmd.take_sel = rk4_pkg::DIV_THREE;
				cmd.div_go   = sts.div_done && !sts.ts_zero;
				cmd.go_sel   = rk4_pkg::DIV_TS;
			end
			rk4_pkg::ST_DIVT: begin
				cmd.div_take = sts.div_done;
				cmd.take_sel = rk4_pkg::DIV_TS;
				cmd.go_sel   = rk4_pkg::DIV_TS;
			end
			rk4_pkg::ST_FIN:  cmd.fin = 1'b1;
			default:          cmd = '0;
		endcase
	end

	assign busy = state_q != rk4_pkg::ST_IDLE;

	a_take_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_take |-> sts.div_done)
		else $error("divider result taken without done");
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");
	a_fin_single: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> !cmd.fin && !busy)
		else $error("finish not a single cycle");
	a_no_zero_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rk4_pkg::ST_DIVT) |-> !sts.ts_zero)
		else $error("division by zero time step started");

endmodule

// ----- dv/rk4_increment_checker.sv -----
// Checker for the RK4 stage increment core: predicts each result word and compares it.
`timescale 1ns / 1ps
module rk4_increment_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic                                  busy,
	input  logic [rk4_pkg::IDX_WIDTH-1:0]         compartment,
	input  logic signed [rk4_pkg::MODE_WIDTH-1:0] stage_mode,
	input  logic signed [31:0]                    rate,
	input  logic [rk4_pkg::TS_WIDTH-1:0]          time_step,
	input  logic                                  clear_max_error,
	input  logic                                  done,
	input  logic signed [31:0]                    increment,
	input  logic [30:0]                           max_error,
	input  logic                                  divide_by_zero,
	output int                                    fail_count,
	output int                                    pending,
	output int                                    words_checked
);
	import rk4_pkg::*;

	localparam longint VMAX = 64'sd2147483647;
	localparam longint VMIN = -64'sd2147483648;

	typedef struct {
		logic signed [31:0] increment;
		logic [30:0]        max_error;
		logic               divide_by_zero;
	} inc_word_t;

	longint    k1_row [COMPARTMENTS];
	longint    k2_row [COMPARTMENTS];
	longint    k3_row [COMPARTMENTS];
	longint    peak_error;
	inc_word_t expected_words [$];

	function automatic longint sat(longint x);
		if (x > VMAX) return VMAX;
		if (x < VMIN) return VMIN;
		return x;
	endfunction

	function automatic longint scale_by_step(longint x, longint ts);
		longint m;
		m = (x < 0) ? -x : x;
		m = (m * ts) >>> 16;
		return sat((x < 0) ? -m : m);
	endfunction

	function automatic longint divide_by_step(longint x, longint ts);
		longint m;
		m = (x < 0) ? -x : x;
		m = (m <<< 16) / ts;
		return sat((x < 0) ? -m : m);
	endfunction

	function automatic inc_word_t next_increment(int idx, logic signed [4:0] mode,
			longint r, longint ts, logic clr);
		inc_word_t w;
		longint t1, t2, t3, dv, inc, nt2, e;
		t1 = k1_row[idx];
		t2 = k2_row[idx];
		t3 = k3_row[idx];
		inc = 0;
		w.divide_by_zero = 1'b0;
		if (clr)
			peak_error = 0;
		dv = scale_by_step((mode < 0) ? t1 : r, ts);
		case (mode)
			MODE_EULER: begin
				k1_row[idx] = r;
				k2_row[idx] = dv;
				k3_row[idx] = dv;
				inc = dv;
			end
			MODE_RK1: begin
				k1_row[idx] = dv;
				inc = dv / 2;
			end
			MODE_RK2: begin
				k2_row[idx] = dv;
				inc = sat(dv - t1) / 2;
			end
			MODE_RK3: begin
				k3_row[idx] = dv;
				inc = sat(dv - t2 / 2);
			end
			MODE_RK4: begin
				nt2 = sat((t1 + 2 * t2 + 2 * t3 + dv) / 6);
				inc = sat(nt2 - t3);
				k2_row[idx] = nt2;
				k3_row[idx] = sat((-t1 + 2 * t3 + 2 * dv) / 3);
				if (ts == 0) begin
					w.divide_by_zero = 1'b1;
					k1_row[idx] = (t1 > 0) ? VMAX : ((t1 < 0) ? VMIN : 0);
				end else begin
					k1_row[idx] = divide_by_step(t1, ts);
				end
			end
			MODE_UNDO_EULER: begin
				inc = sat(dv - t2);
				k2_row[idx] = dv;
				k3_row[idx] = dv;
			end
			MODE_UNDO_RK: begin
				k1_row[idx] = dv;
				inc = sat(dv / 2 - t2);
			end
			MODE_ERR_CHECK: begin
				e = dv - t3;
				if (e < 0)
					e = -e;
				if (e > peak_error)
					peak_error = e;
			end
			default: ;
		endcase
		w.increment = inc[31:0];
		w.max_error = (peak_error > VMAX) ? 31'h7fffffff : peak_error[30:0];
		return w;
	endfunction

	assign pending = expected_words.size();

	initial begin
		for (int i = 0; i < COMPARTMENTS; i++) begin
			k1_row[i] = 0;
			k2_row[i] = 0;
			k3_row[i] = 0;
		end
		peak_error = 0;
		fail_count = 0;
		words_checked = 0;
	end

	always @(posedge clk) begin
		inc_word_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_words.size() == 0) begin
					$display("%0t: result word with none expected: inc %0d err %0d dz %0b",
						$time, increment, max_error, divide_by_zero);
					fail_count++;
				end else begin
					want = expected_words.pop_front();
					words_checked++;
					if (want.increment !== increment) begin
						$display("%0t: increment expected %0d actual %0d",
							$time, want.increment, increment);
						fail_count++;
					end
					if (want.max_error !== max_error) begin
						$display("%0t: max_error expected %0d actual %0d",
							$time, want.max_error, max_error);
						fail_count++;
					end
					if (want.divide_by_zero !== divide_by_zero) begin
						$display("%0t: divide_by_zero expected %0b actual %0b",
							$time, want.divide_by_zero, divide_by_zero);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				expected_words.push_back(next_increment(compartment, stage_mode,
					longint'(rate), longint'(time_step), clear_max_error));
		end
	end

endmodule

// ----- dv/rk4_stage_increment_core_tb.sv -----
// Testbench top for the RK4 stage increment core: stimulus, idling and verdict.
`timescale 1ns / 1ps
module rk4_stage_increment_core_tb;
	import rk4_pkg::*;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic [IDX_WIDTH-1:0]          compartment;
	logic signed [MODE_WIDTH-1:0]  stage_mode;
	logic signed [31:0]            rate;
	logic [TS_WIDTH-1:0]           time_step;
	logic                          clear_max_error;
	logic                          done;
	logic signed [31:0]            increment;
	logic [30:0]                   max_error;
	logic                          divide_by_zero;
	int                            fail_count;
	int                            pending;
	int                            words_checked;
	int                            idle_pct;
	int                            words_sent;

	rk4_stage_increment_core DUT (.*);

	rk4_increment_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		compartment = '0;
		stage_mode = '0;
		rate = '0;
		time_step = '0;
		clear_max_error = 1'b0;
		idle_pct = 0;
		words_sent = 0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_word(int idx, logic signed [4:0] mode, logic signed [31:0] r,
			logic [30:0] ts, logic clr);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		compartment <= idx[7:0];
		stage_mode <= mode;
		rate <= r;
		time_step <= ts;
		clear_max_error <= clr;
		start <= 1'b1;
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
		words_sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [31:0] pick_rate();
		case ($urandom_range(5))
			0:       return $urandom();
			1:       return $urandom_range(1, 3) == 1 ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed($urandom_range(32'h3ffff)) - 32'sh1ffff;
		endcase
	endfunction

	function automatic logic [30:0] pick_step();
		case ($urandom_range(7))
			0:       return 31'($urandom());
			1:       return '0;
			default: return 31'($urandom_range(31'h1ffff));
		endcase
	endfunction

	function automatic logic signed [4:0] pick_odd_mode();
		logic signed [4:0] m;
		m = $signed(5'($urandom()));
		while (m == MODE_UNDO_RK || m == MODE_UNDO_EULER || m == MODE_ERR_CHECK ||
				(m >= MODE_EULER && m <= MODE_RK4))
			m = $signed(5'($urandom()));
		return m;
	endfunction

	task automatic rk_sequence(int idx);
		send_word(idx, MODE_EULER, pick_rate(), pick_step(), 1'b0);
		send_word(idx, MODE_RK1, pick_rate(), pick_step(), 1'b0);
		send_word(idx, MODE_RK2, pick_rate(), pick_step(), 1'b0);
		send_word(idx, MODE_RK3, pick_rate(), pick_step(), 1'b0);
		if ($urandom_range(3) == 0)
			send_word(idx, MODE_UNDO_RK, pick_rate(), pick_step(), 1'b0);
		send_word(idx, MODE_RK4, pick_rate(), ($urandom_range(9) == 0) ? '0 : pick_step(),
			$urandom_range(15) == 0);
		send_word(idx, MODE_ERR_CHECK, pick_rate(), pick_step(), 1'b0);
		if ($urandom_range(4) == 0)
			send_word(idx, MODE_UNDO_EULER, pick_rate(), pick_step(), 1'b0);
	endtask

	initial begin
		int idx;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(0, MODE_EULER, 32'sh7fffffff, 31'h7fffffff, 1'b0);
		send_word(0, MODE_RK1, 32'sh80000000, 31'h7fffffff, 1'b0);
		send_word(0, MODE_RK2, 32'sh00010000, 31'h00010000, 1'b0);
		send_word(0, MODE_RK3, -32'sh00030000, 31'h00008000, 1'b0);
		send_word(0, MODE_RK4, 32'sh00020000, 31'h00000000, 1'b0);
		send_word(0, MODE_ERR_CHECK, 32'sh7fffffff, 31'h7fffffff, 1'b0);
		send_word(1, MODE_RK1, -32'sh00050000, 31'h00020000, 1'b0);
		send_word(1, MODE_RK4, 32'sh00010000, 31'h00000000, 1'b0);
		send_word(2, MODE_RK4, 32'sh00010000, 31'h00000000, 1'b0);
		send_word(3, MODE_RK1, 32'sh00050000, 31'h00000001, 1'b0);
		send_word(3, MODE_RK4, 32'sh00010000, 31'h00000003, 1'b0);
		send_word(255, MODE_EULER, -32'sh00012345, 31'h00018000, 1'b0);
		send_word(255, MODE_UNDO_EULER, 32'sh00000000, 31'h00010000, 1'b0);
		send_word(255, MODE_UNDO_RK, 32'sh00000000, 31'h00020000, 1'b0);
		send_word(255, MODE_ERR_CHECK, 32'sh00100000, 31'h00010000, 1'b1);
		send_word(4, 5'sd7, 32'sh7fffffff, 31'h7fffffff, 1'b1);
		send_word(4, -5'sd16, 32'sh12345678, 31'h00010000, 1'b0);
		send_word(4, 5'sd15, 32'sh00000000, 31'h00000000, 1'b0);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 28 : ((ph == 1) ? 84 : 0);
			while (words_sent < 18 + 430 * (ph + 1)) begin
				idx = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(7);
				if ($urandom_range(4) != 0)
					rk_sequence(idx);
				else if ($urandom_range(1) == 0)
					send_word(idx, pick_odd_mode(), pick_rate(), pick_step(),
						1'($urandom()));
				else
					send_word(idx, $urandom_range(1) ? MODE_ERR_CHECK :
						$signed(5'($urandom_range(4))),
						pick_rate(), pick_step(), $urandom_range(7) == 0);
			end
			drain();
		end

		repeat (200) @(posedge clk);
		$display("Sent %0d words over three idling phases; %0d result words checked.",
			words_sent, words_checked);
		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("Timeout waiting for result words");
		$display("Some tests failed");
		$finish;
	end

endmodule
